### src/tpi_pkg.sv
// tpi_pkg: shared widths, reset constants and the item type passed from the
// classifier front end to the divide back end. No dependencies.
package tpi_pkg;

  localparam int COORD_W = 24;
  localparam int VAL_W   = 32;
  localparam int TOL_W   = 40;
  localparam int IN_W    = 8 * COORD_W + 3 * VAL_W;  // 288, already whole bytes

  localparam int DIFF_W  = COORD_W + 1;   // coordinate differences
  localparam int DZ_W    = VAL_W + 1;     // value differences
  localparam int NZ_W    = 51;            // doubled signed area
  localparam int NXY_W   = 59;            // nx and ny cross terms
  localparam int NUM_W   = 85;            // signed numerator
  localparam int MAG_W   = 84;            // numerator magnitude
  localparam int QBITS   = 33;            // quotient bits before saturation

  localparam logic [TOL_W-1:0] TOL_RESET = 40'd4295;

  typedef struct packed {
    logic                     colin;
    logic                     nz_neg;
    logic [NZ_W-1:0]          nzm;
    logic signed [NXY_W-1:0]  nx;
    logic signed [NXY_W-1:0]  ny;
    logic signed [DIFF_W-1:0] dpx;
    logic signed [DIFF_W-1:0] dpy;
    logic signed [VAL_W-1:0]  z1;
  } front_item_t;

endpackage

### src/tpi_front.sv
// tpi_front: accepts input beats, forms differences, cross products and the
// doubled area, and flags colinear triangles. Depends on tpi_pkg.
module tpi_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tpi_pkg::IN_W-1:0]  in_data,
  input  logic [tpi_pkg::TOL_W-1:0] tol,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tpi_pkg::front_item_t      out_item
);
  import tpi_pkg::*;

  logic a_valid, b_valid, c_valid, d_valid;
  logic en;

  logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3, qx, qy;
  logic signed [VAL_W-1:0]   z1i, z2i, z3i;

  logic signed [DIFF_W-1:0] dx2, dy2, dx3, dy3, a_dpx, a_dpy;
  logic signed [DZ_W-1:0]   dz2, dz3;
  logic signed [VAL_W-1:0]  a_z1;

  logic signed [NZ_W-2:0]   p_nz0, p_nz1;
  logic signed [NXY_W-2:0]  p_nx0, p_nx1, p_ny0, p_ny1;
  logic signed [DIFF_W-1:0] b_dpx, b_dpy;
  logic signed [VAL_W-1:0]  b_z1;

  logic signed [NZ_W-1:0]   nz;
  logic signed [NXY_W-1:0]  c_nx, c_ny;
  logic signed [DIFF_W-1:0] c_dpx, c_dpy;
  logic signed [VAL_W-1:0]  c_z1;

  logic [NZ_W-1:0] nzm_next;

  assign x1  = in_data[0*COORD_W +: COORD_W];
  assign y1  = in_data[1*COORD_W +: COORD_W];
  assign x2  = in_data[2*COORD_W +: COORD_W];
  assign y2  = in_data[3*COORD_W +: COORD_W];
  assign x3  = in_data[4*COORD_W +: COORD_W];
  assign y3  = in_data[5*COORD_W +: COORD_W];
  assign qx  = in_data[6*COORD_W +: COORD_W];
  assign qy  = in_data[7*COORD_W +: COORD_W];
  assign z1i = in_data[8*COORD_W +: VAL_W];
  assign z2i = in_data[8*COORD_W + VAL_W +: VAL_W];
  assign z3i = in_data[8*COORD_W + 2*VAL_W +: VAL_W];

  // whole front pipe moves together unless the last stage is blocked
  assign en       = !d_valid || out_ready;
  assign in_ready = en;

  assign nzm_next = nz[NZ_W-1] ? NZ_W'(-nz) : NZ_W'(nz);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2   <= {x2[COORD_W-1], x2} - {x1[COORD_W-1], x1};
      dy2   <= {y2[COORD_W-1], y2} - {y1[COORD_W-1], y1};
      dx3   <= {x3[COORD_W-1], x3} - {x1[COORD_W-1], x1};
      dy3   <= {y3[COORD_W-1], y3} - {y1[COORD_W-1], y1};
      a_dpx <= {qx[COORD_W-1], qx} - {x1[COORD_W-1], x1};
      a_dpy <= {qy[COORD_W-1], qy} - {y1[COORD_W-1], y1};
      dz2   <= {z2i[VAL_W-1], z2i} - {z1i[VAL_W-1], z1i};
      dz3   <= {z3i[VAL_W-1], z3i} - {z1i[VAL_W-1], z1i};
      a_z1  <= z1i;

      p_nz0 <= dx2 * dy3;
      p_nz1 <= dy2 * dx3;
      p_nx0 <= dy2 * dz3;
      p_nx1 <= dz2 * dy3;
      p_ny0 <= dz2 * dx3;
      p_ny1 <= dx2 * dz3;
      b_dpx <= a_dpx;
      b_dpy <= a_dpy;
      b_z1  <= a_z1;

      nz    <= {p_nz0[NZ_W-2], p_nz0} - {p_nz1[NZ_W-2], p_nz1};
      c_nx  <= {p_nx0[NXY_W-2], p_nx0} - {p_nx1[NXY_W-2], p_nx1};
      c_ny  <= {p_ny0[NXY_W-2], p_ny0} - {p_ny1[NXY_W-2], p_ny1};
      c_dpx <= b_dpx;
      c_dpy <= b_dpy;
      c_z1  <= b_z1;

      out_item.colin  <= (nz == '0) || (nzm_next < {{(NZ_W-TOL_W){1'b0}}, tol});
      out_item.nz_neg <= nz[NZ_W-1];
      out_item.nzm    <= nzm_next;
      out_item.nx     <= c_nx;
      out_item.ny     <= c_ny;
      out_item.dpx    <= c_dpx;
      out_item.dpy    <= c_dpy;
      out_item.z1     <= c_z1;
    end
  end

  assign out_valid = d_valid;

endmodule

### src/tpi_fifo.sv
// tpi_fifo: small queue of classified items between front and back.
// Depends on tpi_pkg.
module tpi_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  tpi_pkg::front_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output tpi_pkg::front_item_t pop_item
);
  import tpi_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  front_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

### src/tpi_back.sv
// tpi_back: numerator products, pipelined restoring divide, sign fix-up and
// saturation into the output register. Depends on tpi_pkg.
module tpi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tpi_pkg::front_item_t       in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tpi_pkg::VAL_W-1:0]  out_value,
  output logic                       out_error
);
  import tpi_pkg::*;

  typedef struct packed {
    logic [MAG_W-1:0]        rem;
    logic [QBITS-1:0]        q;
    logic [NZ_W-1:0]         d;
    logic                    qneg;
    logic                    ovf;
    logic                    colin;
    logic signed [VAL_W-1:0] z1;
  } div_t;

  logic en;
  logic s1_valid, s2_valid, s3_valid;
  logic [QBITS:0] dv_valid;
  div_t dv [QBITS+1];
  div_t dv_next [QBITS];
  logic [MAG_W-1:0] dsh [QBITS];
  logic [QBITS-1:0] ge;

  // stage 1: split partial products
  logic signed [55:0] pxl, pyl;
  logic signed [53:0] pxh, pyh;
  logic s1_colin, s1_nzneg;
  logic [NZ_W-1:0] s1_nzm;
  logic signed [VAL_W-1:0] s1_z1;

  // stage 2: signed numerator
  logic signed [NUM_W-1:0] num;
  logic s2_colin, s2_nzneg;
  logic [NZ_W-1:0] s2_nzm;
  logic signed [VAL_W-1:0] s2_z1;

  // stage 3: magnitude
  logic [MAG_W-1:0] nmag;
  logic s3_colin, s3_qneg;
  logic [NZ_W-1:0] s3_nzm;
  logic signed [VAL_W-1:0] s3_z1;

  logic signed [NUM_W-1:0] num_neg;

  // output fix-up
  logic [QBITS:0]          qs;
  logic signed [QBITS+1:0] qv;
  logic signed [QBITS+2:0] v;
  logic [VAL_W-1:0]        v_sat;
  div_t                    last;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign num_neg  = -num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      dv_valid  <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      dv_valid  <= {dv_valid[QBITS-1:0], s3_valid};
      out_valid <= dv_valid[QBITS];
    end
  end

  // one quotient bit per stage, msb first
  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      dsh[k]     = {{(MAG_W-NZ_W){1'b0}}, dv[k].d} << (QBITS - 1 - k);
      ge[k]      = dv[k].rem >= dsh[k];
      dv_next[k] = dv[k];
      if (ge[k]) dv_next[k].rem = dv[k].rem - dsh[k];
      dv_next[k].q[QBITS-1-k] = ge[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl      <= in_item.dpx * $signed({1'b0, in_item.nx[29:0]});
      pxh      <= in_item.dpx * $signed(in_item.nx[NXY_W-1:30]);
      pyl      <= in_item.dpy * $signed({1'b0, in_item.ny[29:0]});
      pyh      <= in_item.dpy * $signed(in_item.ny[NXY_W-1:30]);
      s1_colin <= in_item.colin;
      s1_nzneg <= in_item.nz_neg;
      s1_nzm   <= in_item.nzm;
      s1_z1    <= in_item.z1;

      num <= {pxh[53], pxh, 30'b0} + {{29{pxl[55]}}, pxl}
           + {pyh[53], pyh, 30'b0} + {{29{pyl[55]}}, pyl};
      s2_colin <= s1_colin;
      s2_nzneg <= s1_nzneg;
      s2_nzm   <= s1_nzm;
      s2_z1    <= s1_z1;

      nmag     <= num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
      s3_qneg  <= num[NUM_W-1] ^ s2_nzneg;
      s3_colin <= s2_colin;
      s3_nzm   <= s2_nzm;
      s3_z1    <= s2_z1;

      // quotient of 2^33 or more saturates regardless of z1
      dv[0].rem   <= nmag;
      dv[0].q     <= '0;
      dv[0].d     <= s3_nzm;
      dv[0].qneg  <= s3_qneg;
      dv[0].ovf   <= nmag >= {s3_nzm, {QBITS{1'b0}}};
      dv[0].colin <= s3_colin;
      dv[0].z1    <= s3_z1;

      for (int k = 0; k < QBITS; k++) begin
        dv[k+1] <= dv_next[k];
      end
    end
  end

  assign last = dv[QBITS];

  always_comb begin
    qs = last.ovf ? {1'b1, {QBITS{1'b0}}} : {1'b0, last.q};
    qv = last.qneg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    v  = {{4{last.z1[VAL_W-1]}}, last.z1} - {qv[QBITS+1], qv};
    if (v > $signed({{3{1'b0}}, 1'b0, {(VAL_W-1){1'b1}}}))
      v_sat = {1'b0, {(VAL_W-1){1'b1}}};
    else if (v < $signed({{3{1'b1}}, 1'b1, {(VAL_W-1){1'b0}}}))
      v_sat = {1'b1, {(VAL_W-1){1'b0}}};
    else
      v_sat = v[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= last.colin ? '0 : v_sat;
      out_error <= last.colin;
    end
  end

endmodule

### src/triangle_plane_interpolator.sv
// triangle_plane_interpolator: top level, front classifier, queue and
// divide back end. Depends on tpi_pkg, tpi_front, tpi_fifo, tpi_back.
//
// usage
//   s_axis carries one query per beat: three vertices, the query point and
//   one component of the three vertex values. m_axis returns one beat per
//   query with the plane value at the query point, or zero with
//   colinear_error set when the doubled area is below the tolerance.
//   cfg_valid/cfg_ready/cfg_data write colinear_tolerance (Q8.32); write
//   it only while no beats are in flight.
// timing
//   one beat accepted per cycle sustained while m_axis_tready stays high;
//   an input beat with no stall passes through 4 front stages, the queue,
//   4 product/magnitude stages, 33 divide stages (one quotient bit each)
//   and the output register. the divide chain sets the latency.
// reset
//   rst clears all valid bits and the queue and loads the tolerance reset
//   value 4295 (about 1e-6).
// stall
//   when m_axis_tready is low and an output beat waits, the back end
//   freezes; the front keeps filling the queue and s_axis_tready drops
//   only once the queue is full and the last front stage holds a beat.
module triangle_plane_interpolator #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y, query_x,
  // query_y, first_value, second_value, third_value (lowest first)
  input  logic [tpi_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tpi_pkg::VAL_W-1:0]   m_axis_tdata,  // result_value
  output logic                        m_axis_tuser,  // colinear_error
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tpi_pkg::TOL_W-1:0]   cfg_data       // colinear_tolerance
);
  import tpi_pkg::*;

  logic [TOL_W-1:0] colinear_tolerance;

  logic        fr_valid, fr_ready;
  front_item_t fr_item;
  logic        q_valid, q_ready;
  front_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      colinear_tolerance <= TOL_RESET;
    end else if (cfg_valid) begin
      colinear_tolerance <= cfg_data;
    end
  end

  tpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .tol       (colinear_tolerance),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  tpi_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  tpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (m_axis_tdata),
    .out_error (m_axis_tuser)
  );

  // a flagged triangle never carries a value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("colinear beat with nonzero value");

  // front only backs up when its last stage is held by a full queue
  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> fr_valid && !fr_ready)
    else $error("input stalled without a full queue");

  // back end stalls only while the output beat waits
  a_back_stall: assert property (@(posedge clk) disable iff (rst)
    !q_ready |-> m_axis_tvalid && !m_axis_tready)
    else $error("back end stalled without output backpressure");

endmodule
